// ===== sv/ndd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Packet destination decode package
// Shared widths, codes and item types of the destination decode pipeline.
// ----------------------------------------------------------------------------
package ndd_pkg;

    localparam int ROUTERS_DEF      = 32;
    localparam int BPE_DEF          = 16;

    // Routers are summed in groups of this size in the first stage.
    localparam int GROUP_SIZE       = 8;

    localparam int COUNT_W          = 4;
    localparam int LOCAL_W          = 7;
    localparam int DEST_W           = 9;
    localparam int ROW_W            = 5;
    localparam int COLS_W           = 6;
    localparam int PORT_W           = 4;
    localparam int LEN_W            = 12;
    localparam int COUNT_ELEM_W     = 8;
    localparam int MSG_W            = 2;
    localparam int CFG_IDX_W        = 2;
    localparam int CFG_DATA_W       = 64;

    localparam int REQUEST_LENGTH   = 29;
    localparam int LENGTH_MAX       = 4095;

    localparam logic [CFG_IDX_W-1:0] CFG_ROUTER_COLUMNS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NI_COUNTS_LOW  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NI_COUNTS_HIGH = 2'd2;

    typedef enum logic [MSG_W-1:0] {
        MSG_READ_REQ  = 2'd0,
        MSG_READ_RSP  = 2'd1,
        MSG_WRITE_REQ = 2'd2,
        MSG_FINAL     = 2'd3
    } ndd_msg_t;

    typedef struct packed {
        logic [MSG_W-1:0]        msg_type;
        logic [COUNT_ELEM_W-1:0] element_count;
        logic [DEST_W-1:0]       destination;
    } ndd_in_t;

    typedef struct packed {
        logic [ROW_W-1:0]  dest_row;
        logic [ROW_W-1:0]  dest_column;
        logic [PORT_W-1:0] dest_port;
        logic [LEN_W-1:0]  length_bits;
        logic              packet_class;
        logic              dest_valid;
    } ndd_out_t;

    // Per-item fields that ride along beside the router search and the divider.
    typedef struct packed {
        logic [PORT_W-1:0] port;
        logic [LEN_W-1:0]  length_bits;
        logic              packet_class;
        logic              dest_valid;
    } ndd_tag_t;

endpackage
`default_nettype wire

// ===== sv/ndd_prefix.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Decode stage one: group prefix sums and packet length
// Sums interface counts inside each group of routers and decodes the length and class.
// ----------------------------------------------------------------------------
module ndd_prefix
    import ndd_pkg::*;
#(
    parameter int  ROUTERS          = ROUTERS_DEF,
    parameter int  BITS_PER_ELEMENT = BPE_DEF,
    localparam int NGROUPS          = (ROUTERS + GROUP_SIZE - 1) / GROUP_SIZE,
    localparam int SLOTS            = NGROUPS * GROUP_SIZE
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire ndd_in_t            in_item,
    input  wire logic [COUNT_W-1:0] ni_count [SLOTS],
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [DEST_W-1:0]       out_dest,
    output ndd_tag_t                out_tag,
    output logic [LOCAL_W-1:0]      out_local_end [SLOTS]
);

    localparam int PROD_W = COUNT_ELEM_W + $clog2(BITS_PER_ELEMENT + 1);
    localparam logic [LEN_W-1:0] ELEM_LEN = (BITS_PER_ELEMENT > LENGTH_MAX) ?
                                            LEN_W'(LENGTH_MAX) : LEN_W'(BITS_PER_ELEMENT);

    logic                valid_reg;
    logic [DEST_W-1:0]   dest_reg;
    ndd_tag_t            tag_reg;
    ndd_tag_t            tag_next;
    logic [LOCAL_W-1:0]  local_end_reg  [SLOTS];
    logic [LOCAL_W-1:0]  local_end_next [SLOTS];
    logic [PROD_W-1:0]   prod;

    assign in_ready = !valid_reg || out_ready;

    // Running sum inside each group; the groups are joined in the next stage.
    always_comb
    begin
        logic [LOCAL_W-1:0] acc;
        for (int g = 0; g < NGROUPS; g++)
        begin
            acc = '0;
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                acc = acc + LOCAL_W'(ni_count[g * GROUP_SIZE + k]);
                local_end_next[g * GROUP_SIZE + k] = acc;
            end
        end
    end

    assign prod = PROD_W'(in_item.element_count) * PROD_W'(BITS_PER_ELEMENT);

    always_comb
    begin
        tag_next = '0;
        unique case (ndd_msg_t'(in_item.msg_type))
            MSG_READ_REQ:
            begin
                tag_next.length_bits  = LEN_W'(REQUEST_LENGTH);
                tag_next.packet_class = 1'b0;
            end
            MSG_READ_RSP:
            begin
                if (32'(prod) > 32'(LENGTH_MAX))
                begin
                    tag_next.length_bits = LEN_W'(LENGTH_MAX);
                end
                else
                begin
                    tag_next.length_bits = LEN_W'(prod);
                end
                tag_next.packet_class = 1'b0;
            end
            MSG_WRITE_REQ, MSG_FINAL:
            begin
                tag_next.length_bits  = ELEM_LEN;
                tag_next.packet_class = 1'b1;
            end
            default:
            begin
                tag_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            dest_reg      <= in_item.destination;
            tag_reg       <= tag_next;
            local_end_reg <= local_end_next;
        end
    end

    assign out_valid     = valid_reg;
    assign out_dest      = dest_reg;
    assign out_tag       = tag_reg;
    assign out_local_end = local_end_reg;

endmodule
`default_nettype wire

// ===== sv/ndd_locate.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Decode stages two and three: router search
// Joins group sums into range ends, then picks the first router that owns
// the destination and its local port.
// ----------------------------------------------------------------------------
module ndd_locate
    import ndd_pkg::*;
#(
    parameter int  ROUTERS = ROUTERS_DEF,
    localparam int NGROUPS = (ROUTERS + GROUP_SIZE - 1) / GROUP_SIZE,
    localparam int SLOTS   = NGROUPS * GROUP_SIZE
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [DEST_W-1:0]  in_dest,
    input  wire ndd_tag_t           in_tag,
    input  wire logic [LOCAL_W-1:0] in_local_end [SLOTS],
    input  wire logic [COUNT_W-1:0] ni_count [SLOTS],
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic [ROW_W-1:0]        out_router,
    output ndd_tag_t                out_tag
);

    logic               a_valid_reg;
    logic [DEST_W-1:0]  a_dest_reg;
    ndd_tag_t           a_tag_reg;
    logic [DEST_W-1:0]  a_end_reg  [SLOTS];
    logic [DEST_W-1:0]  a_end_next [SLOTS];

    logic               b_valid_reg;
    logic [ROW_W-1:0]   b_router_reg;
    logic [ROW_W-1:0]   b_router_next;
    ndd_tag_t           b_tag_reg;
    ndd_tag_t           b_tag_next;

    logic               a_adv;
    logic               b_adv;

    assign b_adv    = !b_valid_reg || out_ready;
    assign a_adv    = !a_valid_reg || b_adv;
    assign in_ready = a_adv;

    // Absolute end of each router's range: group base plus local sum.
    always_comb
    begin
        logic [DEST_W-1:0] base;
        base = '0;
        for (int g = 0; g < NGROUPS; g++)
        begin
            for (int k = 0; k < GROUP_SIZE; k++)
            begin
                a_end_next[g * GROUP_SIZE + k] =
                    base + DEST_W'(in_local_end[g * GROUP_SIZE + k]);
            end
            base = base + DEST_W'(in_local_end[g * GROUP_SIZE + GROUP_SIZE - 1]);
        end
    end

    // Ends never decrease, so the lowest router whose end lies above the
    // destination owns it. Routers without interfaces never win.
    always_comb
    begin
        logic              found;
        logic [ROW_W-1:0]  sel;
        logic [DEST_W-1:0] sel_end;
        logic [DEST_W-1:0] sel_n;
        found   = 1'b0;
        sel     = '0;
        sel_end = '0;
        sel_n   = '0;
        for (int r = SLOTS - 1; r >= 0; r--)
        begin
            if (a_dest_reg < a_end_reg[r])
            begin
                found   = 1'b1;
                sel     = ROW_W'(r);
                sel_end = a_end_reg[r];
                sel_n   = DEST_W'(ni_count[r]);
            end
        end
        b_tag_next            = a_tag_reg;
        b_tag_next.dest_valid = found;
        if (found)
        begin
            b_router_next   = sel;
            b_tag_next.port = PORT_W'(a_dest_reg - (sel_end - sel_n));
        end
        else
        begin
            b_router_next   = '0;
            b_tag_next.port = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_adv)
            begin
                a_valid_reg <= in_valid;
            end
            if (b_adv)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && a_adv)
        begin
            a_dest_reg <= in_dest;
            a_tag_reg  <= in_tag;
            a_end_reg  <= a_end_next;
        end
        if (a_valid_reg && b_adv)
        begin
            b_router_reg <= b_router_next;
            b_tag_reg    <= b_tag_next;
        end
    end

    assign out_valid  = b_valid_reg;
    assign out_router = b_router_reg;
    assign out_tag    = b_tag_reg;

endmodule
`default_nettype wire

// ===== sv/ndd_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Pipelined router index divider
// Restoring division, one quotient bit per stage, giving row and column.
// ----------------------------------------------------------------------------
module ndd_div
    import ndd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [ROW_W-1:0]  dividend,
    input  wire logic [COLS_W-1:0] divisor,
    input  wire ndd_tag_t          in_tag,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [ROW_W-1:0]       quotient,
    output logic [ROW_W-1:0]       remainder,
    output ndd_tag_t               out_tag
);

    logic [ROW_W-1:0]  v_reg;
    logic [ROW_W-1:0]  adv;
    logic [COLS_W-1:0] rem_reg  [ROW_W];
    logic [COLS_W-1:0] rem_next [ROW_W];
    logic [ROW_W-1:0]  qd_reg   [ROW_W];
    logic [ROW_W-1:0]  qd_next  [ROW_W];
    ndd_tag_t          tag_reg  [ROW_W];

    // The dividend shifts out at the top while quotient bits shift in below.
    function automatic void div_step(
        input  logic [COLS_W-1:0] rem_i,
        input  logic [ROW_W-1:0]  qd_i,
        input  logic [COLS_W-1:0] d,
        output logic [COLS_W-1:0] rem_o,
        output logic [ROW_W-1:0]  qd_o
    );
        logic [COLS_W:0] t;
        logic            q;
        t = {rem_i, qd_i[ROW_W-1]};
        if (t >= {1'b0, d})
        begin
            rem_o = COLS_W'(t - {1'b0, d});
            q     = 1'b1;
        end
        else
        begin
            rem_o = t[COLS_W-1:0];
            q     = 1'b0;
        end
        qd_o = {qd_i[ROW_W-2:0], q};
    endfunction

    always_comb
    begin
        adv[ROW_W-1] = !v_reg[ROW_W-1] || out_ready;
        for (int k = ROW_W - 2; k >= 0; k--)
        begin
            adv[k] = !v_reg[k] || adv[k+1];
        end
    end

    always_comb
    begin
        div_step('0, dividend, divisor, rem_next[0], qd_next[0]);
        for (int k = 1; k < ROW_W; k++)
        begin
            div_step(rem_reg[k-1], qd_reg[k-1], divisor, rem_next[k], qd_next[k]);
        end
    end

    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int k = 1; k < ROW_W; k++)
            begin
                if (adv[k])
                begin
                    v_reg[k] <= v_reg[k-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && adv[0])
        begin
            rem_reg[0] <= rem_next[0];
            qd_reg[0]  <= qd_next[0];
            tag_reg[0] <= in_tag;
        end
        for (int k = 1; k < ROW_W; k++)
        begin
            if (v_reg[k-1] && adv[k])
            begin
                rem_reg[k] <= rem_next[k];
                qd_reg[k]  <= qd_next[k];
                tag_reg[k] <= tag_reg[k-1];
            end
        end
    end

    assign out_valid = v_reg[ROW_W-1];
    assign quotient  = qd_reg[ROW_W-1];
    assign remainder = ROW_W'(rem_reg[ROW_W-1]);
    assign out_tag   = tag_reg[ROW_W-1];

endmodule
`default_nettype wire

// ===== sv/noc_packet_destination_decode_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// NoC packet destination decode unit
// Maps a flat network-interface number to mesh row, column and local port,
// and decodes packet length and class from the message type.
// ----------------------------------------------------------------------------
// The unit takes one header item per cycle while the output side is not
// stalled and returns one decoded item for each, in order, through eight
// pipeline stages: one for the per-group sums of the configured
// interface counts and the length decode, two for joining those sums into
// router range ends and picking the owning router, and five for the
// restoring divider that splits the router index into row and column, one
// quotient bit per stage. The divider stage count follows the five-bit row
// width. Backpressure on the output stalls the pipeline stage by stage, so
// bubbles are squeezed out and no item is dropped or repeated. A destination
// at or above the total of the configured interface counts comes back with
// dest_valid low and row, column and port at zero; length and class are
// still given. A column count of zero is treated as one. Configuration
// writes are taken in every cycle and must only be made while no items are
// in flight, since the later stages read the registers directly.
// ----------------------------------------------------------------------------
module noc_packet_destination_decode_unit
    import ndd_pkg::*;
#(
    parameter int ROUTERS          = ROUTERS_DEF,
    parameter int BITS_PER_ELEMENT = BPE_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  hdr_valid,
    output logic                       hdr_ready,
    input  wire ndd_in_t               hdr,
    output logic                       dec_valid,
    input  wire logic                  dec_ready,
    output ndd_out_t                   dec,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int NGROUPS = (ROUTERS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int SLOTS   = NGROUPS * GROUP_SIZE;
    localparam logic [LEN_W-1:0] ELEM_LEN = (BITS_PER_ELEMENT > LENGTH_MAX) ?
                                            LEN_W'(LENGTH_MAX) : LEN_W'(BITS_PER_ELEMENT);

    // Configuration registers.
    logic [COLS_W-1:0]     router_columns_reg;
    logic [CFG_DATA_W-1:0] ni_counts_low_reg;
    logic [CFG_DATA_W-1:0] ni_counts_high_reg;

    logic [2*CFG_DATA_W-1:0] counts_flat;
    logic [COUNT_W-1:0]      ni_count [SLOTS];
    logic [COLS_W-1:0]       cols_eff;

    // Stage one to the router search.
    logic               p_valid;
    logic               p_ready;
    logic [DEST_W-1:0]  p_dest;
    ndd_tag_t           p_tag;
    logic [LOCAL_W-1:0] p_local_end [SLOTS];

    // Router search to the divider.
    logic               l_valid;
    logic               l_ready;
    logic [ROW_W-1:0]   l_router;
    ndd_tag_t           l_tag;

    // Divider results.
    logic [ROW_W-1:0]   d_row;
    logic [ROW_W-1:0]   d_col;
    ndd_tag_t           d_tag;

    // Configuration writes are always taken; an index past the list is dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            router_columns_reg <= COLS_W'(4);
            ni_counts_low_reg  <= 64'h1111_1111_1111_1111;
            ni_counts_high_reg <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_ROUTER_COLUMNS: router_columns_reg <= cfg_data[COLS_W-1:0];
                CFG_NI_COUNTS_LOW:  ni_counts_low_reg  <= cfg_data;
                CFG_NI_COUNTS_HIGH: ni_counts_high_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // Router r uses nibble r of the two count words. Slots beyond the
    // configured router count read as empty so they can never own an item.
    assign counts_flat = {ni_counts_high_reg, ni_counts_low_reg};

    always_comb
    begin
        for (int r = 0; r < SLOTS; r++)
        begin
            if (r < ROUTERS)
            begin
                ni_count[r] = counts_flat[r * COUNT_W +: COUNT_W];
            end
            else
            begin
                ni_count[r] = '0;
            end
        end
    end

    assign cols_eff = (router_columns_reg == '0) ? COLS_W'(1) : router_columns_reg;

    ndd_prefix #(
        .ROUTERS          (ROUTERS),
        .BITS_PER_ELEMENT (BITS_PER_ELEMENT)
    ) u_prefix (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (hdr_valid),
        .in_ready      (hdr_ready),
        .in_item       (hdr),
        .ni_count      (ni_count),
        .out_valid     (p_valid),
        .out_ready     (p_ready),
        .out_dest      (p_dest),
        .out_tag       (p_tag),
        .out_local_end (p_local_end)
    );

    ndd_locate #(
        .ROUTERS (ROUTERS)
    ) u_locate (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (p_valid),
        .in_ready     (p_ready),
        .in_dest      (p_dest),
        .in_tag       (p_tag),
        .in_local_end (p_local_end),
        .ni_count     (ni_count),
        .out_valid    (l_valid),
        .out_ready    (l_ready),
        .out_router   (l_router),
        .out_tag      (l_tag)
    );

    ndd_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (l_valid),
        .in_ready  (l_ready),
        .dividend  (l_router),
        .divisor   (cols_eff),
        .in_tag    (l_tag),
        .out_valid (dec_valid),
        .out_ready (dec_ready),
        .quotient  (d_row),
        .remainder (d_col),
        .out_tag   (d_tag)
    );

    // The divider's last stage is the output register.
    always_comb
    begin
        dec.dest_row     = d_row;
        dec.dest_column  = d_col;
        dec.dest_port    = d_tag.port;
        dec.length_bits  = d_tag.length_bits;
        dec.packet_class = d_tag.packet_class;
        dec.dest_valid   = d_tag.dest_valid;
    end

    // An unowned destination must come back with all location fields cleared.
    assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && !dec.dest_valid |->
            dec.dest_row == '0 && dec.dest_column == '0 && dec.dest_port == '0)
    else $error("location fields not cleared for an out-of-range destination");

    // A router has at most fifteen interfaces, so a local port never reaches 15.
    assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && dec.dest_valid |-> dec.dest_port < PORT_W'(15))
    else $error("local port outside the owning router's range");

    // Write requests and final results always carry one element.
    assert property (@(posedge clk) disable iff (!rst_n)
        dec_valid && dec.packet_class |-> dec.length_bits == ELEM_LEN)
    else $error("class one item with a length other than one element");

endmodule
`default_nettype wire
